// ===== src/kway_merge_priority_queue_unit_defines.svh =====
// Assertion macros used by the merge queue unit.
`ifndef KWAY_MERGE_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define KWAY_MERGE_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define KWMPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checks that a condition implies a property on the next cycle.
`define KWMPQ_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (prop)) else $error(msg);

`endif

// ===== src/kwmpq_pkg.sv =====
// ----------------------------------------------------------------------------
// kwmpq_pkg
// Status codes, command codes and field widths of the k-way merge priority queue.
// ----------------------------------------------------------------------------
package kwmpq_pkg;

    localparam int KEY_PORT_BITS = 64;
    localparam int RUN_BITS      = 6;
    localparam int TAG_PORT_BITS = 32;
    localparam int OCC_BITS      = 7;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

endpackage

// ===== src/kway_merge_priority_queue_unit.sv =====
// Push, or pop on an empty queue: result registered in the cycle after the request; one request
// per cycle sustained while results are taken.
// Pop with entries: a scan of the entry memory (one read a cycle) finds the winner, and a
// compaction pass moves the entries behind it down; no request is taken in between.
// Reset (aresetn low, synchronous) empties the queue and selects ascending
// order; the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
// kway_merge_priority_queue_unit
// Memory-based min/max priority queue for merging sorted runs.
// ----------------------------------------------------------------------------
`include "kway_merge_priority_queue_unit_defines.svh"

module kway_merge_priority_queue_unit #(
    parameter int QUEUE_DEPTH = 64,
    parameter int KEY_BITS    = 64,
    parameter int TAG_BITS    = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic [kwmpq_pkg::KEY_PORT_BITS-1:0] s_sort_key,
    input  logic [kwmpq_pkg::RUN_BITS-1:0]      s_run_index,
    input  logic [kwmpq_pkg::TAG_PORT_BITS-1:0] s_record_tag,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic [kwmpq_pkg::KEY_PORT_BITS-1:0] m_out_key,
    output logic [kwmpq_pkg::RUN_BITS-1:0]      m_out_run,
    output logic [kwmpq_pkg::TAG_PORT_BITS-1:0] m_out_tag,
    output logic [kwmpq_pkg::OCC_BITS-1:0]      m_occupancy
);
    import kwmpq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = KEY_BITS + RUN_BITS + TAG_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic                desc_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       addr_reg;
    logic                rd_valid_reg;
    logic [CW-1:0]       rd_idx_reg;
    logic                have_best_reg;
    logic [CW-1:0]       best_idx_reg;
    logic [KEY_BITS-1:0] best_key_reg;
    logic [RUN_BITS-1:0] best_run_reg;
    logic [TAG_BITS-1:0] best_tag_reg;

    logic                     m_valid_reg;
    status_t                  status_reg;
    logic [KEY_PORT_BITS-1:0] out_key_reg;
    logic [RUN_BITS-1:0]      out_run_reg;
    logic [TAG_PORT_BITS-1:0] out_tag_reg;
    logic [CW-1:0]            occ_reg;

    logic [EW-1:0] mem [QUEUE_DEPTH];
    logic [EW-1:0] rd_data_reg;

    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [EW-1:0]       wr_data;
    logic                out_free;
    logic                accept;
    logic                issue;
    logic                result_load;
    logic [KEY_BITS-1:0] rd_key;
    logic [RUN_BITS-1:0] rd_run;
    logic [TAG_BITS-1:0] rd_tag;
    logic                rd_wins;
    logic [CW-1:0]       wr_idx;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign issue    = ((state_reg == ST_SCAN) || (state_reg == ST_SHIFT))
                      && (addr_reg < count_reg);

    // A result is loaded at once for a push or an empty pop, else when the pop finishes.
    assign result_load = (accept && !((s_cmd == CMD_POP) && (count_reg != '0)))
                         || ((state_reg == ST_DONE) && out_free);

    assign rd_key = rd_data_reg[EW-1 -: KEY_BITS];
    assign rd_run = rd_data_reg[TAG_BITS +: RUN_BITS];
    assign rd_tag = rd_data_reg[TAG_BITS-1:0];

    // Strict comparison keeps the earlier entry on a full tie, which
    // preserves push order among equal key and run.
    always_comb begin
        if (rd_key != best_key_reg) begin
            rd_wins = desc_reg ? (rd_key > best_key_reg) : (rd_key < best_key_reg);
        end else begin
            rd_wins = rd_run < best_run_reg;
        end
    end

    assign wr_idx  = rd_idx_reg - CW'(1);
    assign rd_en   = issue;
    assign rd_addr = addr_reg[AW-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = {s_sort_key[KEY_BITS-1:0], s_run_index, s_record_tag[TAG_BITS-1:0]};
        if (accept && (s_cmd == CMD_PUSH) && (count_reg < CW'(QUEUE_DEPTH))) begin
            wr_en = 1'b1;
        end else if ((state_reg == ST_SHIFT) && rd_valid_reg) begin
            wr_en   = 1'b1;
            wr_addr = wr_idx[AW-1:0];
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            desc_reg      <= 1'b0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
            rd_valid_reg  <= 1'b0;
            have_best_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                desc_reg <= cfg_wdata;
            end
            if (result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            rd_valid_reg <= issue;
            if (issue) begin
                rd_idx_reg <= addr_reg;
                addr_reg   <= addr_reg + CW'(1);
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        out_key_reg <= '0;
                        out_run_reg <= '0;
                        out_tag_reg <= '0;
                        if (s_cmd == CMD_PUSH) begin
                            if (count_reg < CW'(QUEUE_DEPTH)) begin
                                status_reg <= STATUS_OK;
                                count_reg  <= count_reg + CW'(1);
                                occ_reg    <= count_reg + CW'(1);
                            end else begin
                                status_reg <= STATUS_FULL;
                                occ_reg    <= count_reg;
                            end
                        end else if (count_reg == '0) begin
                            status_reg  <= STATUS_EMPTY;
                            occ_reg     <= count_reg;
                        end else begin
                            state_reg     <= ST_SCAN;
                            addr_reg      <= '0;
                            have_best_reg <= 1'b0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (rd_valid_reg && (!have_best_reg || rd_wins)) begin
                        have_best_reg <= 1'b1;
                        best_idx_reg  <= rd_idx_reg;
                        best_key_reg  <= rd_key;
                        best_run_reg  <= rd_run;
                        best_tag_reg  <= rd_tag;
                    end
                    if (!issue && !rd_valid_reg) begin
                        state_reg <= ST_SHIFT;
                        addr_reg  <= best_idx_reg + CW'(1);
                    end
                end
                ST_SHIFT: begin
                    if (!issue && !rd_valid_reg) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        status_reg  <= STATUS_OK;
                        out_key_reg <= KEY_PORT_BITS'(best_key_reg);
                        out_run_reg <= best_run_reg;
                        out_tag_reg <= TAG_PORT_BITS'(best_tag_reg);
                        count_reg   <= count_reg - CW'(1);
                        occ_reg     <= count_reg - CW'(1);
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = status_reg;
    assign m_out_key   = out_key_reg;
    assign m_out_run   = out_run_reg;
    assign m_out_tag   = out_tag_reg;
    assign m_occupancy = OCC_BITS'(occ_reg);

    `KWMPQ_ASSERT(a_count_bound, count_reg <= CW'(QUEUE_DEPTH), "count above depth")
    `KWMPQ_ASSERT(a_shift_in_range,
        !(wr_en && (state_reg == ST_SHIFT)) || (wr_idx < count_reg),
        "compaction write beyond held entries")
    `KWMPQ_ASSERT_NEXT(a_pop_scans,
        accept && (s_cmd == CMD_POP) && (count_reg != '0), state_reg == ST_SCAN,
        "pop with entries did not start a scan")

endmodule
